// ===== hw/rtl/fic_pkg.sv =====
// ----------------------------------------------------------------------------
// fic_pkg
// Shared types and constants for the Fenwick-tree inversion counter.
// ----------------------------------------------------------------------------
package fic_pkg;

  localparam int unsigned RankW  = 11;  // rank field width
  localparam int unsigned TreeW  = 11;  // tree entry width, wraps
  localparam int unsigned TotalW = 20;  // running total, saturating
  localparam int unsigned OutW   = 19;  // emitted total, saturating

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_UPDATE,
    ST_FINISH
  } fic_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the incoming word
    logic query;     // walk the prefix-sum path
    logic upd_init;  // reload the position for the update walk
    logic update;    // walk the increment path
    logic emit;      // present the total and zero it
    logic clear;     // sweep one tree entry to zero
  } fic_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rank_ok;
    logic last;
    logic q_done;
    logic u_done;
    logic clr_done;
  } fic_status_t;

endpackage

// ===== hw/rtl/fic_ctrl.sv =====
// ----------------------------------------------------------------------------
// fic_ctrl
// Sequencer: tree clear, prefix query, increment walk, result emission.
// ----------------------------------------------------------------------------
module fic_ctrl import fic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  fic_status_t status_i,
  output fic_cmd_t    cmd_o,
  output logic        busy_o
);

  fic_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_QUERY;
      end
      ST_QUERY: begin
        if (!status_i.rank_ok) begin
          state_d = ST_FINISH;
        end else if (status_i.q_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (status_i.u_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = status_i.last ? ST_CLEAR : ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_QUERY: begin
        cmd_o.query    = status_i.rank_ok;
        cmd_o.upd_init = status_i.rank_ok & status_i.q_done;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.emit = status_i.last;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fic_datapath.sv =====
// ----------------------------------------------------------------------------
// fic_datapath
// Tree memory, walk position, running total and result register.
// ----------------------------------------------------------------------------
module fic_datapath import fic_pkg::*; #(
  parameter int unsigned SIZE = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fic_cmd_t          cmd_i,
  input  logic [RankW-1:0]  rank_i,
  input  logic              last_element_i,
  output fic_status_t       status_o,
  output logic              result_strobe_o,
  output logic [OutW-1:0]   inversion_total_o
);

  localparam int unsigned AW = $clog2(SIZE);
  // position must hold SIZE plus its lowest set bit
  localparam int unsigned PW = $clog2(SIZE + 1) + 1;
  localparam int unsigned CW = (PW > RankW) ? PW : RankW;

  logic [TreeW-1:0]  mem_q [SIZE];
  logic [TreeW-1:0]  rdata_q;

  logic [PW-1:0]     pos_q, pos_d;
  logic [RankW-1:0]  rank_q;
  logic              last_q, ok_q;
  logic              qpend_q, qpend_d;
  logic              upend_q, upend_d;
  logic [AW-1:0]     wa_q, wa_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [TotalW-1:0] total_q, total_d;
  logic              out_valid_q, out_valid_d;
  logic [OutW-1:0]   out_total_q, out_total_d;

  logic [CW-1:0]     rank_ext;
  logic              rank_in_range;
  logic [PW-1:0]     lowbit;
  logic              q_step, u_step;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [TreeW-1:0]  wr_data;
  logic [TotalW:0]   sum;

  assign rank_ext      = CW'(rank_i);
  assign rank_in_range = (rank_ext != '0) && (rank_ext <= CW'(SIZE));
  assign lowbit        = pos_q & (~pos_q + PW'(1));

  assign q_step = cmd_i.query  && (pos_q != '0);
  assign u_step = cmd_i.update && (pos_q <= PW'(SIZE));

  assign rd_en   = q_step || u_step;
  assign rd_addr = AW'(pos_q - PW'(1));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wa_q;
    wr_data = rdata_q + TreeW'(1);
    if (cmd_i.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else if (upend_q) begin
      wr_en = 1'b1;
    end
  end

  // walk addresses rise strictly, so the write never meets the read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  assign sum = {1'b0, total_q} + (TotalW + 1)'(rdata_q);

  always_comb begin
    pos_d       = pos_q;
    qpend_d     = q_step;
    upend_d     = u_step;
    wa_d        = u_step ? rd_addr : wa_q;
    clr_d       = clr_q;
    total_d     = total_q;
    out_valid_d = 1'b0;
    out_total_d = out_total_q;

    if (cmd_i.load) begin
      pos_d = PW'(rank_ext - CW'(1));
    end else if (cmd_i.upd_init) begin
      pos_d = PW'(CW'(rank_q));
    end else if (q_step) begin
      pos_d = pos_q - lowbit;
    end else if (u_step) begin
      pos_d = pos_q + lowbit;
    end

    // saturating add per term equals saturating the whole sum
    if (qpend_q) begin
      total_d = sum[TotalW] ? '1 : sum[TotalW-1:0];
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_total_d = total_q[TotalW-1] ? '1 : total_q[OutW-1:0];
      total_d     = '0;
    end

    if (cmd_i.clear) begin
      total_d = '0;
      clr_d   = (clr_q == AW'(SIZE - 1)) ? '0 : clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      qpend_q     <= 1'b0;
      upend_q     <= 1'b0;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      qpend_q     <= qpend_d;
      upend_q     <= upend_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.load) begin
        ok_q   <= rank_in_range;
        last_q <= last_element_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q        <= wa_d;
    out_total_q <= out_total_d;
    if (cmd_i.load) rank_q <= rank_i;
  end

  assign status_o.rank_ok  = ok_q;
  assign status_o.last     = last_q;
  assign status_o.q_done   = (pos_q == '0) && !qpend_q;
  assign status_o.u_done   = (pos_q > PW'(SIZE)) && !upend_q;
  assign status_o.clr_done = (clr_q == AW'(SIZE - 1));

  assign result_strobe_o   = out_valid_q;
  assign inversion_total_o = out_total_q;

endmodule

// ===== hw/rtl/fenwick_inversion_counter_core.sv =====
// ----------------------------------------------------------------------------
// fenwick_inversion_counter_core
// Inversion counter over a binary indexed tree held in on-chip memory.
// ----------------------------------------------------------------------------
// Feed the array last element first, one rank (1..SIZE) per word, with
// last_element_i set on the array's first element. A word is taken when start
// is high and busy is low. Each word walks the tree twice through the single
// memory read port, one entry per cycle: the prefix query visits one entry
// per set bit of rank-1 and the increment one per ancestor. The two walks
// touch at most log2(SIZE)+1 entries between them. Out-of-range ranks count
// nothing. On the marked word the total appears on inversion_total_o with
// result_strobe_o high for one cycle; it cannot be held off, so capture it
// then. The tree is then swept clear, one entry per cycle, with busy high;
// the same sweep runs after reset.
// ----------------------------------------------------------------------------
module fenwick_inversion_counter_core import fic_pkg::*; #(
  parameter int unsigned SIZE = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [RankW-1:0]  rank_i,
  input  logic              last_element_i,
  output logic              result_strobe_o,
  output logic [OutW-1:0]   inversion_total_o
);

  fic_cmd_t    cmd;
  fic_status_t status;

  fic_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  fic_datapath #(
    .SIZE (SIZE)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .rank_i            (rank_i),
    .last_element_i    (last_element_i),
    .status_o          (status),
    .result_strobe_o   (result_strobe_o),
    .inversion_total_o (inversion_total_o)
  );

endmodule

// ===== dv/tb_fenwick_inversion_counter_core.sv =====
// ----------------------------------------------------------------------------
// tb_fenwick_inversion_counter_core
// Self-checking bench for the Fenwick-tree inversion counter. Arrays of ranks
// are fed word by word. A local tree model predicts the total for each array,
// and every strobed result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fenwick_inversion_counter_core;
  import fic_pkg::*;

  localparam int unsigned SIZE      = 1024;
  localparam int unsigned TOTAL_MAX = 20'hFFFFF;
  localparam int unsigned OUT_MAX   = 19'h7FFFF;
  localparam int          GAP_MAX   = 13;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [RankW-1:0] rank_i = '0;
  logic            last_element_i = 1'b0;
  logic            result_strobe_o;
  logic [OutW-1:0] inversion_total_o;

  // local copy of the tree and the running count
  logic [TreeW-1:0]  seen_tree [1:SIZE];
  logic [TotalW-1:0] inv_sum;
  logic [OutW-1:0]   pending_totals [$];
  int unsigned       mismatch_cnt = 0;
  int unsigned       words_sent = 0;

  fenwick_inversion_counter_core #(
    .SIZE(SIZE)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .rank_i           (rank_i),
    .last_element_i   (last_element_i),
    .result_strobe_o  (result_strobe_o),
    .inversion_total_o(inversion_total_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned count_below(input int unsigned pos);
    int unsigned acc;
    acc = 0;
    while (pos != 0) begin
      acc += seen_tree[pos];
      pos -= pos & (~pos + 1);
    end
    return acc;
  endfunction

  function automatic void clear_tally();
    for (int i = 1; i <= SIZE; i++) seen_tree[i] = '0;
    inv_sum = '0;
  endfunction

  // apply one accepted word to the model; a marked word queues the total
  function automatic void tally_word(input logic [RankW-1:0] r, input logic is_last);
    int unsigned rv;
    int unsigned sum;
    int unsigned p;
    rv = r;
    if (rv >= 1 && rv <= SIZE) begin
      sum = inv_sum + count_below(rv - 1);
      if (sum > TOTAL_MAX) sum = TOTAL_MAX;
      inv_sum = sum[TotalW-1:0];
      p = rv;
      while (p <= SIZE) begin
        seen_tree[p] = seen_tree[p] + 1'b1;
        p += p & (~p + 1);
      end
    end
    if (is_last) begin
      pending_totals.push_back((inv_sum > OUT_MAX) ? OutW'(OUT_MAX) : inv_sum[OutW-1:0]);
      clear_tally();
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o === 1'b1) begin
      if (pending_totals.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %0d",
                 $time, inversion_total_o);
        mismatch_cnt++;
      end else begin
        if (inversion_total_o !== pending_totals[0]) begin
          $display("%0t: inversion_total mismatch, expected %0d, got %0d",
                   $time, pending_totals[0], inversion_total_o);
          mismatch_cnt++;
        end
        void'(pending_totals.pop_front());
      end
    end
  end

  // start is left high after acceptance so back-to-back words need no toggle
  task automatic send_word(input logic [RankW-1:0] r, input logic is_last, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    rank_i         <= r;
    last_element_i <= is_last;
    do @(posedge clk_i); while (busy !== 1'b0);
    tally_word(r, is_last);
    words_sent++;
  endtask

  task automatic send_array(input int unsigned ranks[$], input int gap_max);
    int gap;
    for (int i = 0; i < ranks.size(); i++) begin
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      send_word(ranks[i][RankW-1:0], i == ranks.size() - 1, gap);
    end
  endtask

  // hold off until every outstanding total has been seen
  task automatic drain_totals();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_totals.size() != 0);
  endtask

  task automatic test_single_elements();
    int unsigned arr[$];
    arr = {1};
    send_array(arr, GAP_MAX);
    arr = {1024};
    send_array(arr, GAP_MAX);
  endtask

  task automatic test_ordering();
    int unsigned arr[$];
    arr = {1, 2, 3, 1024};
    send_array(arr, GAP_MAX);
    arr = {1024, 1};
    send_array(arr, 0);
    arr = {7, 7, 7};
    send_array(arr, GAP_MAX);
  endtask

  // out-of-range ranks count nothing; a marked one still emits
  task automatic test_out_of_range();
    int unsigned arr[$];
    arr = {0, 3, 1025, 2047, 5};
    send_array(arr, GAP_MAX);
    arr = {2, 1, 0};
    send_array(arr, 0);
  endtask

  task automatic test_pause_between_arrays();
    int unsigned arr[$];
    arr = {9, 4, 600, 2, 1000};
    send_array(arr, 3);
    drain_totals();
    arr = {1000, 600, 4};
    send_array(arr, 0);
    drain_totals();
  endtask

  // 2049 hits on rank 1 wrap every entry on its update path
  task automatic test_tree_wrap();
    int unsigned arr[$];
    arr = {};
    for (int i = 0; i < 2049; i++) arr.push_back(1);
    arr.push_back(2);
    arr.push_back(3);
    arr.push_back(1024);
    send_array(arr, 0);
  endtask

  // two ascending sweeps push the running count past its 20-bit ceiling
  task automatic test_total_saturation();
    int unsigned arr[$];
    arr = {};
    for (int k = 0; k < 2; k++)
      for (int r = 1; r <= SIZE; r++) arr.push_back(r);
    send_array(arr, 0);
  endtask

  task automatic test_random_arrays();
    int unsigned arr[$];
    int unsigned first_word;
    int          n_arrays;
    int          len;
    int          mode;
    int          gap_max;
    int unsigned lo;
    int unsigned hi;
    first_word = words_sent;
    n_arrays   = 0;
    while (words_sent - first_word < 1000 || n_arrays < 48) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      mode = $urandom_range(0, 3);
      case (mode)
        0: begin lo = 1;    hi = SIZE; end
        1: begin lo = 1;    hi = 16;   end
        2: begin lo = 1000; hi = SIZE; end
        default: begin
          lo = $urandom_range(1, SIZE);
          hi = (lo + 63 > SIZE) ? SIZE : lo + 63;
        end
      endcase
      arr = {};
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0)
          arr.push_back(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(SIZE + 1, 2047));
        else
          arr.push_back($urandom_range(lo, hi));
      end
      // now and then a broken array whose marked word is out of range
      if ($urandom_range(0, 11) == 0) arr[len-1] = $urandom_range(0, 1) ? 0 : 2047;
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      send_array(arr, gap_max);
      n_arrays++;
      if ($urandom_range(0, 9) == 0) drain_totals();
    end
  endtask

  initial begin
    clear_tally();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single_elements();
    test_ordering();
    test_out_of_range();
    test_pause_between_arrays();
    test_tree_wrap();
    test_total_saturation();
    test_random_arrays();
    start <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fic_pkg.sv
hw/rtl/fic_ctrl.sv
hw/rtl/fic_datapath.sv
hw/rtl/fenwick_inversion_counter_core.sv
dv/tb_fenwick_inversion_counter_core.sv
